### rtl/pip_pkg.sv
// Shared types and codes for the point-in-polygon classifier.
package pip_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic boundary;
    } t_acc_status;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
    localparam logic [1:0] LOC_INSIDE   = 2'd1;
    localparam logic [1:0] LOC_BOUNDARY = 2'd2;

    localparam int OUT_W = 8;

endpackage

### rtl/point_in_polygon_classifier.sv
// Top level of the point-in-polygon classifier: vertex memory, edge walk and result register.
//
// A load request (tuser 0) writes one vertex into the vertex memory. A query
// request (tuser 1) walks the stored polygon through the single read port of the vertex memory,
// one vertex per cycle, then drains the edge pipeline and loads its result into the output
// register once that is free; with vertex_count zero it skips the walk. One request is worked
// at a time, and a new one is taken while a finished result waits in the output register.
// Result codes: 0 outside, 1 inside, 2 on an edge. Vertices read by a query must have been loaded.
module point_in_polygon_classifier import pip_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 31,
    localparam int IDX_W = $clog2(MAX_VERTICES),
    localparam int CNT_W = $clog2(MAX_VERTICES + 1),
    localparam int IN_W  = ((IDX_W + 2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,      // vertex_count
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,    // vertex_index, coord_x, coord_y
    input  logic [0:0]       s_axis_tuser,    // op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata     // location
);

    localparam int WN_W = CNT_W + 1;
    localparam int VW   = 2 * COORD_BITS;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]           r_vcount;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;

    logic [VW-1:0]              mem [MAX_VERTICES];
    logic [VW-1:0]              r_rd_data;
    logic                       r_m_v;
    logic                       r_m_first;
    logic [VW-1:0]              r_prev;

    logic                       r_out_valid;
    logic [1:0]                 r_out_loc;

    logic                       in_acc;
    logic [IDX_W-1:0]           in_idx;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic                       mem_we;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       out_load;
    logic [1:0]                 loc;
    logic                       edge_v;
    t_acc_status                stat;
    logic signed [WN_W-1:0]     wn;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_idx = s_axis_tdata[IDX_W-1:0];
    assign in_x   = s_axis_tdata[IDX_W +: COORD_BITS];
    assign in_y   = s_axis_tdata[IDX_W + COORD_BITS +: COORD_BITS];
    assign mem_we = in_acc && (s_axis_tuser[0] == OP_LOAD)
                    && (CNT_W'(in_idx) < CNT_W'(MAX_VERTICES));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vcount <= (i_cfg_data > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[in_idx] <= {in_y, in_x};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign rd_addr = (r_cnt == r_vcount) ? '0 : r_cnt[IDX_W-1:0];

    always_comb begin
        if (stat.boundary) begin
            loc = LOC_BOUNDARY;
        end else if ((r_vcount >= CNT_W'(3)) && ((wn == WN_W'(1)) || (wn == {WN_W{1'b1}}))) begin
            loc = LOC_INSIDE;
        end else begin
            loc = LOC_OUTSIDE;
        end
    end

    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (s_axis_tuser[0] == OP_QUERY)) begin
                    n_state = (r_vcount == '0) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                rd_en = 1'b1;
                if (r_cnt == r_vcount) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_m_v && !stat.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_m_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_m_v   <= rd_en;
            if (in_acc) begin
                r_cnt <= '0;
            end else if (rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px <= in_x;
            r_py <= in_y;
        end
        if (rd_en) begin
            r_m_first <= (r_cnt == '0);
        end
        if (r_m_v) begin
            r_prev <= r_rd_data;
        end
    end

    assign edge_v = r_m_v && !r_m_first;

    pip_edge_unit #(
        .COORD_BITS (COORD_BITS),
        .WN_W       (WN_W)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (in_acc),
        .i_valid (edge_v),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_ax    (r_prev[COORD_BITS-1:0]),
        .i_ay    (r_prev[VW-1:COORD_BITS]),
        .i_bx    (r_rd_data[COORD_BITS-1:0]),
        .i_by    (r_rd_data[VW-1:COORD_BITS]),
        .o_stat  (stat),
        .o_wn    (wn)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_loc <= loc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W - 2){1'b0}}, r_out_loc};

`ifndef ASSERT_OFF
    a_empty_query_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (s_axis_tuser[0] == OP_QUERY) && (r_vcount == '0)) |=> (r_state == ST_DONE))
        else $error("empty polygon query did not finish at once");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_cnt <= r_vcount))
        else $error("vertex read past vertex count");

    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !m_axis_tready) |=> (r_state == ST_DONE))
        else $error("result dropped while output stalled");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!stat.busy && !r_m_v))
        else $error("edge pipeline busy while idle");
`endif

endmodule

### rtl/pip_edge_unit.sv
// Edge test pipeline: differences, cross products, boundary and winding accumulation.
module pip_edge_unit import pip_pkg::*; #(
    parameter int COORD_BITS = 31,
    parameter int WN_W       = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    output t_acc_status                  o_stat,
    output logic signed [WN_W-1:0]       o_wn
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic                 r_b_v;
    logic signed [DW-1:0] r_dyp;
    logic signed [DW-1:0] r_dxb;
    logic signed [DW-1:0] r_dxp;
    logic signed [DW-1:0] r_dyb;
    logic                 r_b_box;
    logic                 r_b_up;
    logic                 r_b_dn;

    logic                 r_c_v;
    logic signed [PW-1:0] r_p;
    logic signed [PW-1:0] r_q;
    logic                 r_c_box;
    logic                 r_c_up;
    logic                 r_c_dn;

    logic                 r_boundary;
    logic signed [WN_W-1:0] r_wn;

    logic                 in_x;
    logic                 in_y;
    logic signed [PW:0]   diff;
    logic                 d_zero;
    logic                 d_neg;
    logic                 d_pos;

    assign in_x = ((i_px >= i_ax) && (i_px <= i_bx)) || ((i_px >= i_bx) && (i_px <= i_ax));
    assign in_y = ((i_py >= i_ay) && (i_py <= i_by)) || ((i_py >= i_by) && (i_py <= i_ay));

    assign diff   = signed'({r_p[PW-1], r_p}) - signed'({r_q[PW-1], r_q});
    assign d_zero = (diff == '0);
    assign d_neg  = diff[PW];
    assign d_pos  = !d_neg && !d_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_b_v <= i_valid;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dyp   <= signed'({i_py[COORD_BITS-1], i_py}) - signed'({i_ay[COORD_BITS-1], i_ay});
        r_dxb   <= signed'({i_bx[COORD_BITS-1], i_bx}) - signed'({i_ax[COORD_BITS-1], i_ax});
        r_dxp   <= signed'({i_px[COORD_BITS-1], i_px}) - signed'({i_ax[COORD_BITS-1], i_ax});
        r_dyb   <= signed'({i_by[COORD_BITS-1], i_by}) - signed'({i_ay[COORD_BITS-1], i_ay});
        r_b_box <= in_x && in_y;
        r_b_up  <= (i_ay <= i_py) && (i_by > i_py);
        r_b_dn  <= (i_ay > i_py) && (i_by <= i_py);
        r_p     <= r_dyp * r_dxb;
        r_q     <= r_dxp * r_dyb;
        r_c_box <= r_b_box;
        r_c_up  <= r_b_up;
        r_c_dn  <= r_b_dn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_boundary <= 1'b0;
            r_wn       <= '0;
        end else if (r_c_v) begin
            if (r_c_box && d_zero) begin
                r_boundary <= 1'b1;
            end
            if (r_c_up && d_pos) begin
                r_wn <= r_wn + WN_W'(1);
            end else if (r_c_dn && d_neg) begin
                r_wn <= r_wn - WN_W'(1);
            end
        end
    end

    assign o_stat.busy     = r_b_v || r_c_v;
    assign o_stat.boundary = r_boundary;
    assign o_wn            = r_wn;

endmodule

### tb/sv/tb_point_in_polygon_classifier.sv
// Self-checking testbench for the point-in-polygon classifier: vertex loads, queries, count writes.
module tb_point_in_polygon_classifier;
    import pip_pkg::*;

    localparam int MAX_VERT     = 1024;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int IN_W         = 72;
    localparam int WATCH_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 1100;
    localparam int LOAD_SETTLE  = 8;
    localparam int RANDOM_ITEMS = 420;
    localparam int LARGE_VERT   = 128;
    localparam int HOLD_CYCLES  = 300;
    localparam longint COORD_MIN = -(longint'(1) << 30);
    localparam longint COORD_MAX = (longint'(1) << 30) - 1;

    typedef logic signed [30:0] t_coord;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;   // vertex_index, coord_x, coord_y
    logic [0:0]       s_axis_tuser = '0;   // op
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;        // location

    longint     vx_mem [MAX_VERT];
    longint     vy_mem [MAX_VERT];
    int         n_vertices = 0;
    logic [1:0] loc_expected [$];
    logic [1:0] exp_loc;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int errors        = 0;
    int loads_sent    = 0;
    int queries_sent  = 0;
    int results_seen  = 0;
    int count_writes  = 0;

    point_in_polygon_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int cross_sign(longint a, longint b, longint c, longint d);
        logic signed [127:0] wa, wb, wc, wd, diff;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        diff = wa * wb - wc * wd;
        if (diff < 0) return -1;
        return (diff == 0) ? 0 : 1;
    endfunction

    function automatic bit on_segment(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by);
        if (px < ((ax < bx) ? ax : bx) || px > ((ax < bx) ? bx : ax)) return 1'b0;
        if (py < ((ay < by) ? ay : by) || py > ((ay < by) ? by : ay)) return 1'b0;
        return cross_sign(py - ay, bx - ax, px - ax, by - ay) == 0;
    endfunction

    function automatic logic [1:0] locate_point(longint px, longint py);
        int wn;
        int j;
        int s;
        wn = 0;
        for (int i = 0; i < n_vertices; i++) begin
            j = (i + 1 == n_vertices) ? 0 : i + 1;
            if (on_segment(px, py, vx_mem[i], vy_mem[i], vx_mem[j], vy_mem[j]))
                return LOC_BOUNDARY;
        end
        if (n_vertices < 3) return LOC_OUTSIDE;
        for (int i = 0; i < n_vertices; i++) begin
            j = (i + 1 == n_vertices) ? 0 : i + 1;
            s = cross_sign(vx_mem[j] - vx_mem[i], py - vy_mem[i],
                           px - vx_mem[i], vy_mem[j] - vy_mem[i]);
            if (vy_mem[i] <= py) begin
                if (vy_mem[j] > py && s > 0) wn++;
            end else if (vy_mem[j] <= py && s < 0) begin
                wn--;
            end
        end
        return (wn == 1 || wn == -1) ? LOC_INSIDE : LOC_OUTSIDE;
    endfunction

    function automatic t_coord rand_coord(int scale);
        if (scale == 0) return t_coord'($urandom());
        return t_coord'($urandom_range(0, 2 * scale) - scale);
    endfunction

    task automatic set_idle(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic send_request(logic op, logic [IDX_W-1:0] idx, t_coord x, t_coord y);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x, idx};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_LOAD) begin
            vx_mem[idx] = x;
            vy_mem[idx] = y;
            loads_sent++;
        end else begin
            loc_expected.push_back(locate_point(x, y));
            queries_sent++;
        end
    endtask

    task automatic query_point(t_coord x, t_coord y);
        send_request(OP_QUERY, IDX_W'($urandom()), x, y);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (loc_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_count(int value);
        wait_drained();
        // let a trailing vertex write settle before touching the count
        repeat (LOAD_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        n_vertices = (value > MAX_VERT) ? MAX_VERT : value;
        count_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_polygon();
        set_idle(17, 70);
        query_point(t_coord'(COORD_MIN), t_coord'(COORD_MIN));
        query_point(t_coord'(COORD_MAX), t_coord'(COORD_MAX));
    endtask

    task automatic test_short_polygons();
        send_request(OP_LOAD, 0, 7, -3);
        write_count(1);
        query_point(7, -3);
        query_point(8, -3);
        send_request(OP_LOAD, 0, -4, -4);
        send_request(OP_LOAD, 1, 4, 4);
        write_count(2);
        query_point(0, 0);
        query_point(1, 0);
        write_count(0);
        query_point(0, 0);
    endtask

    task automatic test_extreme_triangle();
        send_request(OP_LOAD, 0, t_coord'(COORD_MIN), t_coord'(COORD_MIN));
        send_request(OP_LOAD, 1, t_coord'(COORD_MIN), t_coord'(COORD_MAX));
        send_request(OP_LOAD, 2, t_coord'(COORD_MAX), t_coord'(COORD_MIN));
        write_count(3);
        query_point(t_coord'(COORD_MIN + 1), t_coord'(COORD_MIN + 1));
        query_point(-1, 0);
        query_point(t_coord'(COORD_MAX), t_coord'(COORD_MAX));
    endtask

    task automatic test_double_winding();
        send_request(OP_LOAD, 0, 0, 100);
        send_request(OP_LOAD, 1, 59, -81);
        send_request(OP_LOAD, 2, -95, 31);
        send_request(OP_LOAD, 3, 95, 31);
        send_request(OP_LOAD, 4, -59, -81);
        write_count(5);
        query_point(0, 0);
        query_point(0, 90);
    endtask

    task automatic test_random_polygons();
        int n;
        int scale;
        int sent;
        int phase;
        int pick;
        int i;
        int j;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent < RANDOM_ITEMS / 3) set_idle(17, 70);
            else if (sent < 2 * RANDOM_ITEMS / 3) set_idle(70, 17);
            else set_idle(0, 0);
            pick = $urandom_range(0, 9);
            n = (pick == 0) ? $urandom_range(13, 64) :
                (pick == 1) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            pick = $urandom_range(0, 3);
            scale = (pick == 0) ? 8 : (pick == 1) ? 40 : (pick == 2) ? 100000 : 0;
            for (i = 0; i < n; i++)
                send_request(OP_LOAD, IDX_W'(i), rand_coord(scale), rand_coord(scale));
            write_count(n);
            sent += n;
            if (phase % 4 == 3) begin
                // hold the output side so the block backs up
                hold_request = HOLD_CYCLES;
                repeat (6) query_point(rand_coord(scale), rand_coord(scale));
                wait_drained();
                sent += 6;
            end
            repeat ($urandom_range(8, 20)) begin
                pick = $urandom_range(0, 99);
                i = $urandom_range(0, n - 1);
                j = (i + 1) % n;
                if (pick < 45) begin
                    query_point(rand_coord(scale), rand_coord(scale));
                end else if (pick < 55) begin
                    query_point(t_coord'(vx_mem[i]), t_coord'(vy_mem[i]));
                end else if (pick < 70) begin
                    query_point(t_coord'((vx_mem[i] + vx_mem[j]) >>> 1),
                                t_coord'((vy_mem[i] + vy_mem[j]) >>> 1));
                end else if (pick < 78) begin
                    query_point(rand_coord(0), rand_coord(0));
                end else if (pick < 92) begin
                    send_request(OP_LOAD, IDX_W'(i), rand_coord(scale), rand_coord(scale));
                end else begin
                    send_request(OP_LOAD, IDX_W'($urandom_range(0, MAX_VERT - 1)),
                                 rand_coord(0), rand_coord(0));
                end
                sent++;
            end
            phase++;
        end
    endtask

    task automatic test_large_polygon();
        int k;
        int t;
        set_idle(0, 0);
        for (k = 0; k < LARGE_VERT; k++) begin
            t = (k % 32) * 1000;
            case (k / 32)
                0: send_request(OP_LOAD, IDX_W'(k), t_coord'(t), 0);
                1: send_request(OP_LOAD, IDX_W'(k), 32000, t_coord'(t));
                2: send_request(OP_LOAD, IDX_W'(k), t_coord'(32000 - t), 32000);
                default: send_request(OP_LOAD, IDX_W'(k), 0, t_coord'(32000 - t));
            endcase
        end
        write_count(LARGE_VERT);
        query_point(16000, 16000);
        query_point(0, 500);
        query_point(40000, 5);
        query_point(31999, 32000);
        query_point(-5, -5);
    endtask

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (loc_expected.size() == 0) begin
                errors++;
                $display("%0t: location expected none, actual %0d",
                         $time, m_axis_tdata[1:0]);
            end else begin
                exp_loc = loc_expected.pop_front();
                if (m_axis_tdata[1:0] !== exp_loc) begin
                    errors++;
                    $display("%0t: location expected %0d, actual %0d",
                             $time, exp_loc, m_axis_tdata[1:0]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCH_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_polygon();
        test_short_polygons();
        test_extreme_triangle();
        test_double_winding();
        test_random_polygons();
        test_large_polygon();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d vertex loads, %0d queries, %0d results, %0d count writes,",
                 loads_sent, queries_sent, results_seen, count_writes);
        $display("from empty and two-vertex shapes to a 128-vertex outline, with stalls.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
rtl/pip_pkg.sv
rtl/pip_edge_unit.sv
rtl/point_in_polygon_classifier.sv
tb/sv/tb_point_in_polygon_classifier.sv
